// File: rtl/mac_grid_pressure_relaxation_unit_macros.svh
// Assertion macros shared by the pressure relaxation RTL.
`ifndef MAC_GRID_PRESSURE_RELAXATION_UNIT_MACROS_SVH
`define MAC_GRID_PRESSURE_RELAXATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MGPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define MGPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MGPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MGPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/mgpr_pkg.sv
// Shared types and constants of the pressure relaxation unit.
package mgpr_pkg;

	localparam int COORD_W = 6;
	localparam int VAL_W   = 16;
	// Accumulator holds four pressures minus the divergence.
	localparam int ACC_W   = 20;
	localparam int MAG_W   = 19;
	localparam int Q_W     = 18;
	localparam int P_W     = Q_W + 1;

	// floor(m * RECIP3 >> RECIP3_SHIFT) == floor(m / 3) for m below 2**19.
	localparam int RECIP3_W     = 20;
	localparam logic [RECIP3_W-1:0] RECIP3 = 20'd699051;
	localparam int RECIP3_SHIFT = 21;

	localparam logic signed [P_W-1:0] SAT_HI = 19'sd32767;
	localparam logic signed [P_W-1:0] SAT_LO = -19'sd32768;
	localparam logic signed [VAL_W-1:0] PRES_MAX = 16'sh7fff;
	localparam logic signed [VAL_W-1:0] PRES_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		REQ_WR_XFACE = 2'd0,
		REQ_WR_YFACE = 2'd1,
		REQ_WR_PRES  = 2'd2,
		REQ_RELAX    = 2'd3
	} req_kind_t;

endpackage

// File: rtl/mgpr_req_if.sv
// Request channel: valid/ready plus one write or relax request.
interface mgpr_req_if import mgpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	req_kind_t               req_type;
	logic [COORD_W-1:0]      cell_x;
	logic [COORD_W-1:0]      cell_y;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, req_type, cell_x, cell_y, value, input ready);
	modport sink   (input valid, req_type, cell_x, cell_y, value, output ready);
endinterface

// File: rtl/mgpr_rsp_if.sv
// Response channel: valid/ready plus one relaxation result.
interface mgpr_rsp_if import mgpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] pres_out;
	logic                    coord_error;
	logic                    saturated;

	modport source (output valid, pres_out, coord_error, saturated, input ready);
	modport sink   (input valid, pres_out, coord_error, saturated, output ready);
endinterface

// File: rtl/mgpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mgpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/mac_grid_pressure_relaxation_unit.sv
// Top level: staggered-grid pressure store with in-place one-cell pressure relaxation.
// A write or a coordinate error goes from the transfer straight to S_DONE; a relax passes
// S_READ (4 pressure reads), S_ACC (accumulate), S_DIV (divide) and S_DONE (write back),
// which waits for a free response register. One request at a time; a relax feeds its
// neighbors in turn via the single pressure read port to the shared accumulator. Ready
// is low until done. Reset: async, active low; a clearing pass over max((W+1)*H, W*(H+1))
// addresses (1056 by default) zeroes all three stores before the first request is taken.
`include "mac_grid_pressure_relaxation_unit_macros.svh"

module mac_grid_pressure_relaxation_unit import mgpr_pkg::*; #(
	parameter int GRID_W = 32,
	parameter int GRID_H = 32
) (
	input logic        clk,
	input logic        arst_n,
	mgpr_req_if.sink   req,
	mgpr_rsp_if.source rsp
);

	localparam int P_DEPTH   = GRID_W * GRID_H;
	localparam int XF_DEPTH  = (GRID_W + 1) * GRID_H;
	localparam int YF_DEPTH  = GRID_W * (GRID_H + 1);
	localparam int CLR_DEPTH = (XF_DEPTH > YF_DEPTH) ? XF_DEPTH : YF_DEPTH;
	localparam int PAW       = $clog2(P_DEPTH);
	localparam int XAW       = $clog2(XF_DEPTH);
	localparam int YAW       = $clog2(YF_DEPTH);
	localparam int CW        = $clog2(CLR_DEPTH);

	// One-hot sequencer states.
	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_ACC   = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// Clearing pass counter.
	logic [CW-1:0] clr_q;

	// Captured request.
	req_kind_t               kind_q;
	logic [COORD_W-1:0]      x_q, y_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    err_q;

	// Read sequencer and accumulator.
	logic [1:0]              step_q;
	logic                    rd_s1;
	logic [1:0]              step_s1;
	logic                    nb_ok_s1;
	logic signed [ACC_W-1:0] acc_q;

	// Divider result.
	logic [Q_W-1:0] q_q;
	logic           neg_q;

	// Output register.
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] rsp_pres_q;
	logic                    rsp_err_q;
	logic                    rsp_sat_q;

	logic accept;
	logic out_free;
	logic clearing;
	logic coord_ok;

	assign clearing = (state_q == S_CLEAR);
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// Coordinate check against the store that the request addresses.
	always_comb begin
		unique case (req.req_type)
			REQ_WR_XFACE: coord_ok = (32'(req.cell_x) <= GRID_W) && (32'(req.cell_y) < GRID_H);
			REQ_WR_YFACE: coord_ok = (32'(req.cell_x) < GRID_W) && (32'(req.cell_y) <= GRID_H);
			default:      coord_ok = (32'(req.cell_x) < GRID_W) && (32'(req.cell_y) < GRID_H);
		endcase
	end

	// In-grid neighbors of the captured cell: left, right, below, above.
	logic nb_l, nb_r, nb_b, nb_t;
	logic [2:0] nb_cnt;

	assign nb_l = (x_q != '0);
	assign nb_r = (32'(x_q) + 1 < GRID_W);
	assign nb_b = (y_q != '0);
	assign nb_t = (32'(y_q) + 1 < GRID_H);
	assign nb_cnt = 3'(nb_l) + 3'(nb_r) + 3'(nb_b) + 3'(nb_t);

	// Store addresses of the captured cell and its faces.
	logic [PAW-1:0] c_addr;
	logic [XAW-1:0] xf_cell, xf_right;
	logic [YAW-1:0] yf_cell, yf_top;

	assign c_addr   = PAW'(32'(y_q) * GRID_W + 32'(x_q));
	assign xf_cell  = XAW'(32'(y_q) * (GRID_W + 1) + 32'(x_q));
	assign xf_right = XAW'(32'(y_q) * (GRID_W + 1) + 32'(x_q) + 1);
	assign yf_cell  = YAW'(32'(y_q) * GRID_W + 32'(x_q));
	assign yf_top   = YAW'((32'(y_q) + 1) * GRID_W + 32'(x_q));

	// Read addresses per step: one pressure neighbor each step,
	// the far faces on step 0 and the near faces on step 1.
	logic [PAW-1:0] p_raddr;
	logic [XAW-1:0] xf_raddr;
	logic [YAW-1:0] yf_raddr;
	logic           nb_ok;

	always_comb begin
		unique case (step_q)
			2'd0: begin
				p_raddr = PAW'(32'(c_addr) - 1);
				nb_ok   = nb_l;
			end
			2'd1: begin
				p_raddr = PAW'(32'(c_addr) + 1);
				nb_ok   = nb_r;
			end
			2'd2: begin
				p_raddr = PAW'(32'(c_addr) - GRID_W);
				nb_ok   = nb_b;
			end
			default: begin
				p_raddr = PAW'(32'(c_addr) + GRID_W);
				nb_ok   = nb_t;
			end
		endcase
	end

	assign xf_raddr = (step_q == 2'd0) ? xf_right : xf_cell;
	assign yf_raddr = (step_q == 2'd0) ? yf_top : yf_cell;

	// Read data and the shared accumulate: sum of neighbors minus divergence.
	logic [VAL_W-1:0]        p_rdata, xf_rdata, yf_rdata;
	logic signed [ACC_W-1:0] p_term, xf_term, yf_term, face_term, acc_next;

	always_comb begin
		p_term  = nb_ok_s1 ? ACC_W'($signed(p_rdata)) : '0;
		xf_term = ACC_W'($signed(xf_rdata));
		yf_term = ACC_W'($signed(yf_rdata));
		unique case (step_s1)
			2'd0:    face_term = -(xf_term + yf_term);
			2'd1:    face_term = xf_term + yf_term;
			default: face_term = '0;
		endcase
		acc_next = acc_q + p_term + face_term;
	end

	// Truncating divide by 2, 3 or 4 on the magnitude; 3 goes by reciprocal.
	logic                        acc_neg;
	logic signed [ACC_W-1:0]     acc_abs;
	logic [MAG_W-1:0]            mag;
	logic [MAG_W+RECIP3_W-1:0]   prod3;
	logic [Q_W-1:0]              q_d;

	always_comb begin
		acc_neg = acc_q[ACC_W-1];
		acc_abs = acc_neg ? -acc_q : acc_q;
		mag     = acc_abs[MAG_W-1:0];
		prod3   = (MAG_W+RECIP3_W)'(mag) * (MAG_W+RECIP3_W)'(RECIP3);
		unique case (nb_cnt)
			3'd3:    q_d = prod3[RECIP3_SHIFT +: Q_W];
			3'd4:    q_d = Q_W'(mag >> 2);
			default: q_d = Q_W'(mag >> 1);
		endcase
	end

	// Sign restore and saturation.
	logic signed [P_W-1:0]   q_s, p_val;
	logic                    sat_hi, sat_lo;
	logic signed [VAL_W-1:0] p_sat;

	always_comb begin
		q_s    = $signed({1'b0, q_q});
		p_val  = neg_q ? -q_s : q_s;
		sat_hi = (p_val > SAT_HI);
		sat_lo = (p_val < SAT_LO);
		priority if (sat_hi) begin
			p_sat = PRES_MAX;
		end else if (sat_lo) begin
			p_sat = PRES_MIN;
		end else begin
			p_sat = p_val[VAL_W-1:0];
		end
	end

	// Store writes: clearing pass, or the request's own write at completion.
	logic finish;
	logic is_relax;
	logic p_we, xf_we, yf_we;
	logic [PAW-1:0] p_waddr;
	logic [XAW-1:0] xf_waddr;
	logic [YAW-1:0] yf_waddr;
	logic [VAL_W-1:0] p_wdata, f_wdata;

	assign finish   = (state_q == S_DONE) && out_free;
	assign is_relax = (kind_q == REQ_RELAX);

	always_comb begin
		if (clearing) begin
			p_we     = (32'(clr_q) < P_DEPTH);
			xf_we    = (32'(clr_q) < XF_DEPTH);
			yf_we    = (32'(clr_q) < YF_DEPTH);
			p_waddr  = clr_q[PAW-1:0];
			xf_waddr = clr_q[XAW-1:0];
			yf_waddr = clr_q[YAW-1:0];
			p_wdata  = '0;
			f_wdata  = '0;
		end else begin
			p_we     = finish && !err_q && (kind_q == REQ_WR_PRES || is_relax);
			xf_we    = finish && !err_q && (kind_q == REQ_WR_XFACE);
			yf_we    = finish && !err_q && (kind_q == REQ_WR_YFACE);
			p_waddr  = c_addr;
			xf_waddr = xf_cell;
			yf_waddr = yf_cell;
			p_wdata  = is_relax ? p_sat : value_q;
			f_wdata  = value_q;
		end
	end

	mgpr_ram #(.WIDTH(VAL_W), .DEPTH(P_DEPTH)) u_pres_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	mgpr_ram #(.WIDTH(VAL_W), .DEPTH(XF_DEPTH)) u_xface_ram (
		.clk   (clk),
		.we    (xf_we),
		.waddr (xf_waddr),
		.wdata (f_wdata),
		.raddr (xf_raddr),
		.rdata (xf_rdata)
	);

	mgpr_ram #(.WIDTH(VAL_W), .DEPTH(YF_DEPTH)) u_yface_ram (
		.clk   (clk),
		.we    (yf_we),
		.waddr (yf_waddr),
		.wdata (f_wdata),
		.raddr (yf_raddr),
		.rdata (yf_rdata)
	);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (32'(clr_q) == CLR_DEPTH - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = (req.req_type == REQ_RELAX && coord_ok) ? S_READ : S_DONE;
				end
			end
			S_READ: begin
				if (step_q == 2'd3) begin
					state_d = S_ACC;
				end
			end
			S_ACC:  state_d = S_DIV;
			S_DIV:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			rd_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == S_READ);
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				step_q <= '0;
			end else if (state_q == S_READ) begin
				step_q <= step_q + 1'b1;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.req_type;
			x_q     <= req.cell_x;
			y_q     <= req.cell_y;
			value_q <= req.value;
			err_q   <= !coord_ok;
			acc_q   <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_next;
		end
		step_s1  <= step_q;
		nb_ok_s1 <= nb_ok;
		if (state_q == S_DIV) begin
			q_q   <= q_d;
			neg_q <= acc_neg;
		end
		if (finish) begin
			rsp_pres_q <= (is_relax && !err_q) ? p_sat : '0;
			rsp_err_q  <= err_q;
			rsp_sat_q  <= is_relax && !err_q && (sat_hi || sat_lo);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.pres_out    = rsp_pres_q;
	assign rsp.coord_error = rsp_err_q;
	assign rsp.saturated   = rsp_sat_q;

	`MGPR_ASSERT_IMP(a_sat_extreme, clk, arst_n, rsp.valid && rsp.saturated, rsp.pres_out == PRES_MAX || rsp.pres_out == PRES_MIN, "saturated result is not a range limit")
	`MGPR_ASSERT_IMP(a_err_quiet, clk, arst_n, rsp.valid && rsp.coord_error, rsp.pres_out == '0 && !rsp.saturated, "coordinate error with nonzero result")
	`MGPR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "ready high right after a request transfer")
	`MGPR_ASSERT_IMP(a_pwrite_when, clk, arst_n, p_we && !clearing, state_q == S_DONE && out_free, "pressure store written outside completion")
	`MGPR_ASSERT_IMP(a_rd_in_relax, clk, arst_n, rd_s1, state_q == S_READ || state_q == S_ACC, "read data returned outside a relax")

endmodule
